>>> rtl/mlbc_pkg.sv
// ----------------------------------------------------------------------------
// mlbc_pkg
// Shared types and constants of the multi-LED blink controller.
// ----------------------------------------------------------------------------
package mlbc_pkg;

  // Request kinds carried in tuser
  typedef enum logic [2:0] {
    REQ_SET    = 3'd0,
    REQ_TOGGLE = 3'd1,
    REQ_BLINK  = 3'd2,
    REQ_STOP   = 3'd3,
    REQ_TICK   = 3'd4
  } mlbc_req_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NOT_READY = 2'd1,
    STS_INVALID   = 2'd2
  } mlbc_status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_COMMIT
  } mlbc_state_e;

  localparam int unsigned ReqW     = 3;
  localparam int unsigned IdxW     = 3;
  localparam int unsigned FreqW    = 16;
  localparam int unsigned DurW     = 16;
  localparam int unsigned HalfW    = 19;
  localparam int unsigned ElapsedW = 27;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 16;
  localparam int unsigned OutLeds  = 4;

  // Input tdata layout
  localparam int unsigned IdxLsb   = 0;
  localparam int unsigned OnBit    = 3;
  localparam int unsigned FreqLsb  = 4;
  localparam int unsigned DurLsb   = 20;

  localparam logic [HalfW-1:0]    HalfNum     = 19'd500000;
  localparam int unsigned         DivSteps    = HalfW;
  localparam logic [ElapsedW-1:0] ElapsedMax  = '1;

  typedef struct packed {
    logic load_in;
    logic start_div;
    logic commit;
  } mlbc_cmd_t;

  typedef struct packed {
    logic need_div;
    logic out_free;
    logic div_done;
  } mlbc_sts_t;

endpackage

>>> rtl/mlbc_div.sv
// ----------------------------------------------------------------------------
// mlbc_div
// Restoring divider: half period = 500000 / divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module mlbc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [mlbc_pkg::FreqW-1:0]  divisor_i,
  output logic                        done_o,
  output logic [mlbc_pkg::HalfW-1:0]  quot_o
);

  logic                        busy_q, busy_d;
  logic [4:0]                  cnt_q, cnt_d;
  logic [mlbc_pkg::FreqW-1:0]  rem_q, rem_d;
  logic [mlbc_pkg::FreqW-1:0]  dvs_q, dvs_d;
  logic [mlbc_pkg::HalfW-1:0]  quot_q, quot_d;
  logic [mlbc_pkg::FreqW:0]    trial;
  logic                        ge;

  assign trial = {rem_q, mlbc_pkg::HalfNum[cnt_q]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 5'(mlbc_pkg::DivSteps - 1);
      rem_d  = '0;
      dvs_d  = divisor_i;
      quot_d = '0;
    end else if (busy_q) begin
      rem_d  = ge ? mlbc_pkg::FreqW'(trial - {1'b0, dvs_q}) : trial[mlbc_pkg::FreqW-1:0];
      quot_d = {quot_q[mlbc_pkg::HalfW-2:0], ge};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    quot_q <= quot_d;
  end

  assign done_o = busy_q && (cnt_q == '0);
  assign quot_o = quot_q;

endmodule

>>> rtl/mlbc_ctrl.sv
// ----------------------------------------------------------------------------
// mlbc_ctrl
// Request sequencer: accept, optional division, commit into the output slot.
// ----------------------------------------------------------------------------
module mlbc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  mlbc_pkg::mlbc_sts_t  sts_i,
  output mlbc_pkg::mlbc_cmd_t  cmd_o
);

  mlbc_pkg::mlbc_state_e state_q, state_d;
  logic                  accept;

  assign accept = in_valid_i && (state_q == mlbc_pkg::ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      mlbc_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = sts_i.need_div ? mlbc_pkg::ST_DIV : mlbc_pkg::ST_COMMIT;
        end
      end
      mlbc_pkg::ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = mlbc_pkg::ST_COMMIT;
        end
      end
      mlbc_pkg::ST_COMMIT: begin
        if (sts_i.out_free) begin
          state_d = mlbc_pkg::ST_IDLE;
        end
      end
      default: state_d = mlbc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o      = (state_q == mlbc_pkg::ST_IDLE);
    cmd_o.load_in   = accept;
    cmd_o.start_div = accept && sts_i.need_div;
    cmd_o.commit    = (state_q == mlbc_pkg::ST_COMMIT) && sts_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mlbc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> sts_i.out_free) else $error("commit without free slot");
  a_start_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start_div |=> state_q == mlbc_pkg::ST_DIV) else $error("divide not entered");
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> state_q == mlbc_pkg::ST_DIV) else $error("stray divide done");
  a_commit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> state_q == mlbc_pkg::ST_IDLE) else $error("commit did not end request");

endmodule

>>> rtl/mlbc_dp.sv
// ----------------------------------------------------------------------------
// mlbc_dp
// LED state lanes, request register, tick update and output register.
// ----------------------------------------------------------------------------
module mlbc_dp #(
  parameter int unsigned NUM_LEDS = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mlbc_pkg::mlbc_cmd_t           cmd_i,
  output logic                          need_div_o,
  output logic                          out_free_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  input  logic [mlbc_pkg::ReqW-1:0]     req_i,
  input  logic [mlbc_pkg::InDataW-1:0]  data_i,
  input  logic [mlbc_pkg::HalfW-1:0]    half_i,
  output logic                          m_valid_o,
  input  logic                          m_ready_i,
  output logic [mlbc_pkg::OutDataW-1:0] m_data_o
);

  localparam int unsigned ShowLeds = (NUM_LEDS < mlbc_pkg::OutLeds) ? NUM_LEDS
                                                                    : mlbc_pkg::OutLeds;

  logic                          ready_q;
  logic [mlbc_pkg::ReqW-1:0]     req_q;
  logic [mlbc_pkg::IdxW-1:0]     idx_q;
  logic                          on_q;
  logic                          fzero_q;
  logic [mlbc_pkg::DurW-1:0]     dur_q;

  logic [NUM_LEDS-1:0]           lvl_q, lvl_d, act_q, act_d;
  logic [mlbc_pkg::HalfW-1:0]    half_q [NUM_LEDS];
  logic [mlbc_pkg::HalfW-1:0]    half_d [NUM_LEDS];
  logic [mlbc_pkg::HalfW-1:0]    ph_q   [NUM_LEDS];
  logic [mlbc_pkg::HalfW-1:0]    ph_d   [NUM_LEDS];
  logic [mlbc_pkg::ElapsedW-1:0] el_q   [NUM_LEDS];
  logic [mlbc_pkg::ElapsedW-1:0] el_d   [NUM_LEDS];
  logic [mlbc_pkg::ElapsedW-1:0] lim_q  [NUM_LEDS];
  logic [mlbc_pkg::ElapsedW-1:0] lim_d  [NUM_LEDS];

  logic                          out_valid_q;
  logic [mlbc_pkg::OutDataW-1:0] out_data_q, out_data_d;

  logic [mlbc_pkg::IdxW-1:0]     in_idx;
  logic [mlbc_pkg::FreqW-1:0]    in_freq;
  logic                          idx_ok, cmd_ok, is_tick;
  logic [mlbc_pkg::ElapsedW-1:0] dur_us;
  logic [mlbc_pkg::ElapsedW-1:0] el_n;
  logic [mlbc_pkg::HalfW-1:0]    ph_n;
  mlbc_pkg::mlbc_status_e        status;
  logic [mlbc_pkg::OutLeds-1:0]  lvl_out, act_out;

  assign in_idx  = data_i[mlbc_pkg::IdxLsb +: mlbc_pkg::IdxW];
  assign in_freq = data_i[mlbc_pkg::FreqLsb +: mlbc_pkg::FreqW];

  assign need_div_o = (req_i == mlbc_pkg::REQ_BLINK) && ready_q &&
                      ({1'b0, in_idx} < 4'(NUM_LEDS)) && (in_freq != '0);
  assign out_free_o = !out_valid_q || m_ready_i;

  assign idx_ok  = {1'b0, idx_q} < 4'(NUM_LEDS);
  assign is_tick = (req_q == mlbc_pkg::REQ_TICK);
  assign dur_us  = (mlbc_pkg::ElapsedW'(dur_q) << 10) - (mlbc_pkg::ElapsedW'(dur_q) << 4)
                 - (mlbc_pkg::ElapsedW'(dur_q) << 3);

  always_comb begin
    cmd_ok = 1'b0;
    if (is_tick) begin
      status = mlbc_pkg::STS_OK;
    end else if (req_q > mlbc_pkg::REQ_TICK) begin
      status = mlbc_pkg::STS_INVALID;
    end else if (!ready_q) begin
      status = mlbc_pkg::STS_NOT_READY;
    end else if (!idx_ok) begin
      status = mlbc_pkg::STS_INVALID;
    end else if ((req_q == mlbc_pkg::REQ_BLINK) && fzero_q) begin
      status = mlbc_pkg::STS_INVALID;
    end else begin
      status = mlbc_pkg::STS_OK;
      cmd_ok = 1'b1;
    end
  end

  always_comb begin
    lvl_d = lvl_q;
    act_d = act_q;
    el_n  = '0;
    ph_n  = '0;
    for (int i = 0; i < NUM_LEDS; i++) begin
      half_d[i] = half_q[i];
      ph_d[i]   = ph_q[i];
      el_d[i]   = el_q[i];
      lim_d[i]  = lim_q[i];
      if (is_tick && act_q[i]) begin
        el_n = (el_q[i] != mlbc_pkg::ElapsedMax) ? el_q[i] + 1'b1 : el_q[i];
        ph_n = ph_q[i] + 1'b1;
        el_d[i] = el_n;
        if (ph_n >= half_q[i]) begin
          ph_d[i] = '0;
          if ((lim_q[i] != '0) && (el_n >= lim_q[i])) begin
            act_d[i] = 1'b0;
          end else begin
            lvl_d[i] = !lvl_q[i];
          end
        end else begin
          ph_d[i] = ph_n;
        end
      end
      if (cmd_ok && (idx_q == mlbc_pkg::IdxW'(i))) begin
        act_d[i] = 1'b0;
        case (req_q)
          mlbc_pkg::REQ_SET:    lvl_d[i] = on_q;
          mlbc_pkg::REQ_TOGGLE: lvl_d[i] = !lvl_q[i];
          mlbc_pkg::REQ_STOP:   lvl_d[i] = 1'b0;
          mlbc_pkg::REQ_BLINK: begin
            half_d[i] = half_i;
            ph_d[i]   = '0;
            el_d[i]   = '0;
            lim_d[i]  = dur_us;
            act_d[i]  = 1'b1;
            lvl_d[i]  = 1'b1;
          end
          default: lvl_d[i] = lvl_q[i];
        endcase
      end
    end
  end

  always_comb begin
    lvl_out = '0;
    act_out = '0;
    for (int i = 0; i < ShowLeds; i++) begin
      lvl_out[i] = lvl_d[i];
      act_out[i] = act_d[i];
    end
    out_data_d = {6'b0, act_out, lvl_out, status};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q     <= 1'b0;
      lvl_q       <= '0;
      act_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ready_q <= cfg_wdata_i;
      end
      if (cmd_i.commit) begin
        lvl_q       <= lvl_d;
        act_q       <= act_d;
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      req_q   <= req_i;
      idx_q   <= in_idx;
      on_q    <= data_i[mlbc_pkg::OnBit];
      fzero_q <= (in_freq == '0);
      dur_q   <= data_i[mlbc_pkg::DurLsb +: mlbc_pkg::DurW];
    end
    if (cmd_i.commit) begin
      out_data_q <= out_data_d;
      for (int i = 0; i < NUM_LEDS; i++) begin
        half_q[i] <= half_d[i];
        ph_q[i]   <= ph_d[i];
        el_q[i]   <= el_d[i];
        lim_q[i]  <= lim_d[i];
      end
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_data_q;

endmodule

>>> rtl/multi_led_blink_controller_unit.sv
// Flow: tick, set, toggle and stop requests are registered on acceptance and then
// committed to the LED state and output register; a valid blink request runs the divider first.
// A request is taken only when the previous one has committed; blinks are bounded by
// the one-bit-per-cycle half-period divider; a held result stalls the next commit.
// Reset clears all LEDs to off and not blinking, system ready to 0, output empty.
// ----------------------------------------------------------------------------
// multi_led_blink_controller_unit
// Four-channel LED blink controller driven by requests and microsecond ticks.
// ----------------------------------------------------------------------------
module multi_led_blink_controller_unit #(
  parameter int unsigned NUM_LEDS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,   // system_ready
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // led_index[2:0], turn_on[3], freq_hz[19:4],
                                     // blink_ms[35:20]
  input  logic [2:0]  s_axis_tuser,  // req_type[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // status[1:0], led_levels[5:2], blinking_mask[9:6]
);

  mlbc_pkg::mlbc_cmd_t         cmd;
  mlbc_pkg::mlbc_sts_t         sts;
  logic                        need_div;
  logic                        out_free;
  logic                        div_done;
  logic [mlbc_pkg::HalfW-1:0]  half;

  assign sts.need_div = need_div;
  assign sts.out_free = out_free;
  assign sts.div_done = div_done;

  mlbc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mlbc_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd.start_div),
    .divisor_i (s_axis_tdata[mlbc_pkg::FreqLsb +: mlbc_pkg::FreqW]),
    .done_o    (div_done),
    .quot_o    (half)
  );

  mlbc_dp #(
    .NUM_LEDS (NUM_LEDS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .need_div_o  (need_div),
    .out_free_o  (out_free),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (s_axis_tuser),
    .data_i      (s_axis_tdata),
    .half_i      (half),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (m_axis_tdata)
  );

endmodule
